// ===== rtl/tst_pkg.sv =====
package tst_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned IdW   = 31;
  localparam int unsigned PosW  = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned OpW   = 2;

  typedef enum logic [OpW-1:0] {
    OP_BEGAN     = 2'd0,
    OP_MOVED     = 2'd1,
    OP_ENDED     = 2'd2,
    OP_CANCELLED = 2'd3
  } op_e;

  typedef enum logic [OpW-1:0] {
    PH_PRESSED   = 2'd0,
    PH_MOVED     = 2'd1,
    PH_RELEASED  = 2'd2,
    PH_CANCELLED = 2'd3
  } phase_e;

  typedef logic [IdW-1:0]         id_t;
  typedef logic signed [PosW-1:0] pos_t;

endpackage

// ===== rtl/tst_evt_if.sv =====
interface tst_evt_if;
  import tst_pkg::*;

  logic     valid;
  logic     ready;
  op_e      operation;
  id_t      touch_id;
  pos_t     pos_x;
  pos_t     pos_y;
  logic     last_in_batch;

  modport source (output valid, operation, touch_id, pos_x, pos_y, last_in_batch,
                  input ready);
  modport sink (input valid, operation, touch_id, pos_x, pos_y, last_in_batch,
                output ready);
endinterface

// ===== rtl/tst_res_if.sv =====
interface tst_res_if;
  import tst_pkg::*;

  logic                found;
  logic                valid;
  logic                ready;
  logic [SlotW-1:0]    slot;
  phase_e              touch_phase;
  pos_t                cur_x;
  pos_t                cur_y;
  pos_t                prev_x;
  pos_t                prev_y;
  logic                batch_end;

  modport source (output valid, found, slot, touch_phase, cur_x, cur_y, prev_x, prev_y,
                  batch_end, input ready);
  modport sink (input valid, found, slot, touch_phase, cur_x, cur_y, prev_x, prev_y,
                batch_end, output ready);
endinterface

// ===== rtl/tst_ram.sv =====
module tst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/touch_slot_tracker_unit.sv =====
// Touch slot tracker: matches one touch event per word against a table of NumSlots
// slots. The event is scanned against every slot through a single read port of the
// slot memory and one id comparator, one slot per cycle. The result word is written
// into the output register once the last slot has been compared and that register is
// free; the state machine then returns to idle, so a new event is taken only after
// the last one has finished; the input is not ready during the scan. A finished result
// waits in an output register while the next event is accepted. Busy flags live in
// flip-flops and are cleared by reset, so no clearing pass is needed.
module touch_slot_tracker_unit #(
  parameter int unsigned NumSlots = tst_pkg::NumSlotsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tst_evt_if.sink    evt_i,
  tst_res_if.source  res_o
);
  import tst_pkg::*;

  localparam int unsigned IdxW  = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned CntW  = $clog2(NumSlots + 1);
  localparam int unsigned EntW  = IdW + 2 * PosW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumSlots - 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(NumSlots);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]      state_q, state_d;
  op_e             op_q;
  id_t             id_q;
  pos_t            px_q, py_q;
  logic            last_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            match_q, match_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d;
  pos_t            old_x_q, old_x_d, old_y_q, old_y_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            busy_q [NumSlots];

  logic            out_valid_q;
  logic            out_found_q;
  logic [SlotW-1:0] out_slot_q;
  phase_e          out_phase_q;
  pos_t            out_cx_q, out_cy_q, out_px_q, out_py_q;
  logic            out_last_q;

  logic            evt_acc;
  logic            rd_issue;
  logic [EntW-1:0] rd_data;
  id_t             rd_owner;
  pos_t            rd_x, rd_y;
  logic            hit;
  logic            finish;
  logic            found;
  logic            keep_busy;
  logic [IdxW-1:0] sel_idx;
  logic [IdxW+SlotW-1:0] sel_wide;

  assign evt_acc   = evt_i.valid && evt_i.ready;
  assign evt_i.ready = (state_q == ST_IDLE);

  assign rd_issue = (state_q == ST_SCAN) && (cnt_q != CntEnd);
  assign rd_owner = rd_data[EntW-1 -: IdW];
  assign rd_x     = pos_t'(rd_data[2*PosW-1 -: PosW]);
  assign rd_y     = pos_t'(rd_data[PosW-1:0]);
  assign hit      = rd_vld_q && busy_q[rd_idx_q] && (rd_owner == id_q);

  assign finish    = (state_q == ST_FINISH) && (!out_valid_q || res_o.ready);
  assign found     = match_q || ((op_q == OP_BEGAN) && free_q);
  assign sel_idx   = match_q ? match_idx_q : free_idx_q;
  assign sel_wide  = {{SlotW{1'b0}}, sel_idx};
  assign keep_busy = (op_q == OP_BEGAN) || (op_q == OP_MOVED);

  tst_ram #(
    .Width (EntW),
    .Depth (NumSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (finish && found),
    .waddr_i (sel_idx),
    .wdata_i ({id_q, px_q, py_q}),
    .re_i    (rd_issue),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    old_x_d     = old_x_q;
    old_y_d     = old_y_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    case (state_q)
      ST_IDLE: begin
        if (evt_acc) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          match_d = 1'b0;
          free_d  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_issue) begin
          cnt_d = cnt_q + CntW'(1);
        end
        // The lowest matching slot and the lowest free slot win.
        if (hit && !match_q) begin
          match_d     = 1'b1;
          match_idx_d = rd_idx_q;
          old_x_d     = rd_x;
          old_y_d     = rd_y;
        end
        if (rd_vld_q && !busy_q[rd_idx_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = rd_idx_q;
        end
        if (rd_vld_q && (rd_idx_q == LastIdx)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      match_q     <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumSlots; i++) begin
        busy_q[i] <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_issue;
      match_q  <= match_d;
      free_q   <= free_d;
      if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        if (found) begin
          busy_q[sel_idx] <= keep_busy;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= cnt_q[IdxW-1:0];
    match_idx_q <= match_idx_d;
    old_x_q     <= old_x_d;
    old_y_q     <= old_y_d;
    free_idx_q  <= free_idx_d;
    if (evt_acc) begin
      op_q   <= evt_i.operation;
      id_q   <= evt_i.touch_id;
      px_q   <= evt_i.pos_x;
      py_q   <= evt_i.pos_y;
      last_q <= evt_i.last_in_batch;
    end
    if (finish) begin
      out_last_q  <= last_q;
      out_found_q <= found;
      if (found) begin
        out_slot_q  <= sel_wide[SlotW-1:0];
        out_phase_q <= phase_e'(op_q);
        out_cx_q    <= px_q;
        out_cy_q    <= py_q;
        out_px_q    <= (op_q == OP_BEGAN) ? px_q : old_x_q;
        out_py_q    <= (op_q == OP_BEGAN) ? py_q : old_y_q;
      end else begin
        out_slot_q  <= '0;
        out_phase_q <= PH_PRESSED;
        out_cx_q    <= '0;
        out_cy_q    <= '0;
        out_px_q    <= '0;
        out_py_q    <= '0;
      end
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.found       = out_found_q;
  assign res_o.slot        = out_slot_q;
  assign res_o.touch_phase = out_phase_q;
  assign res_o.cur_x       = out_cx_q;
  assign res_o.cur_y       = out_cy_q;
  assign res_o.prev_x      = out_px_q;
  assign res_o.prev_y      = out_py_q;
  assign res_o.batch_end   = out_last_q;

endmodule

// ===== rtl/tst_checker.sv =====
module tst_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      evt_valid_i,
  input logic                      evt_ready_i,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic                      res_found_i,
  input logic [tst_pkg::SlotW-1:0] res_slot_i,
  input logic [1:0]                res_phase_i,
  input tst_pkg::pos_t             res_cur_x_i,
  input tst_pkg::pos_t             res_cur_y_i,
  input tst_pkg::pos_t             res_prev_x_i,
  input tst_pkg::pos_t             res_prev_y_i
);
  import tst_pkg::*;

  // A word that waits at the output stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_slot_i)
      && $stable(res_cur_x_i) && $stable(res_prev_x_i))
    else $error("result word changed while stalled");

  // The block scans the table after taking an event and cannot take another at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("event accepted while a scan was starting");

  // An event that matches no slot reports all-zero slot data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_found_i |-> res_slot_i == '0 && res_phase_i == PH_PRESSED
      && res_cur_x_i == '0 && res_cur_y_i == '0 && res_prev_x_i == '0 && res_prev_y_i == '0)
    else $error("not-found result carries slot data");

  // A pressed touch has no earlier position, so previous equals current.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_found_i && res_phase_i == PH_PRESSED |->
      res_prev_x_i == res_cur_x_i && res_prev_y_i == res_cur_y_i)
    else $error("pressed touch reports a different previous position");

endmodule

bind touch_slot_tracker_unit tst_checker u_tst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .evt_valid_i  (evt_i.valid),
  .evt_ready_i  (evt_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_found_i  (res_o.found),
  .res_slot_i   (res_o.slot),
  .res_phase_i  (res_o.touch_phase),
  .res_cur_x_i  (res_o.cur_x),
  .res_cur_y_i  (res_o.cur_y),
  .res_prev_x_i (res_o.prev_x),
  .res_prev_y_i (res_o.prev_y)
);
